>>> rtl/svpm_pkg.sv
// package for the servo compare mapper: widths, register indexes, payload and control types
// no dependencies; imported by every module under rtl
package svpm_pkg;

    localparam int CHANNELS    = 4;
    localparam int IN_CHANNELS = 4;
    localparam int LANES       = (CHANNELS < IN_CHANNELS) ? CHANNELS : IN_CHANNELS;

    localparam int POS_W  = 12;
    localparam int CMP_W  = 16;
    localparam int PROD_W = POS_W + CMP_W;

    // quotient is below the compare span, so only CMP_W restoring steps are needed
    localparam int DIV_STEPS = CMP_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_POT_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POT_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;

    typedef struct packed {
        logic [POS_W-1:0] base_position;
        logic [POS_W-1:0] elbow_position;
        logic [POS_W-1:0] wrist_position;
        logic [POS_W-1:0] gripper_position;
        logic             filter_on;
    } t_in_word;

    typedef struct packed {
        logic [CMP_W-1:0] base_compare;
        logic [CMP_W-1:0] elbow_compare;
        logic [CMP_W-1:0] wrist_compare;
        logic [CMP_W-1:0] gripper_compare;
        logic             base_updated;
        logic             elbow_updated;
        logic             wrist_updated;
        logic             gripper_updated;
    } t_out_word;

    typedef struct packed {
        logic [POS_W-1:0] pot_min;
        logic [POS_W-1:0] pot_max;
        logic [CMP_W-1:0] pwm_min;
        logic [CMP_W-1:0] pwm_max;
        logic [CMP_W-1:0] change_threshold;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic mul;
        logic step;
    } t_lane_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

endpackage

>>> rtl/svpm_lane.sv
// one mapping lane: range test, span multiply and restoring divider for one channel
// depends on svpm_pkg; sequenced by the top level through t_lane_ctl
module svpm_lane
    import svpm_pkg::*;
(
    input  logic             i_clk,
    input  t_lane_ctl        i_ctl,
    input  t_cfg             i_cfg,
    input  logic [POS_W-1:0] i_pos,
    output logic [CMP_W-1:0] o_next
);

    logic [POS_W-1:0]  r_num;
    logic              r_lo;
    logic              r_hi;
    logic [POS_W-1:0]  r_rem;
    logic [CMP_W-1:0]  r_quo;

    logic [CMP_W-1:0]  w_span;
    logic [POS_W-1:0]  w_den;
    logic [PROD_W-1:0] w_prod;
    logic [POS_W:0]    w_rem_sh;
    logic [POS_W:0]    w_rem_sub;

    always_comb begin
        w_span    = (i_cfg.pwm_max >= i_cfg.pwm_min) ? (i_cfg.pwm_max - i_cfg.pwm_min)
                                                     : '0;
        w_den     = i_cfg.pot_max - i_cfg.pot_min;
        w_prod    = PROD_W'(r_num) * PROD_W'(w_span);
        w_rem_sh  = {r_rem, r_quo[CMP_W-1]};
        w_rem_sub = w_rem_sh - {1'b0, w_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_num <= i_pos - i_cfg.pot_min;
            r_lo  <= (i_pos <= i_cfg.pot_min);
            r_hi  <= (i_pos >= i_cfg.pot_max);
        end
        if (i_ctl.mul) begin
            r_rem <= w_prod[PROD_W-1:CMP_W];
            r_quo <= w_prod[CMP_W-1:0];
        end else if (i_ctl.step) begin
            if (w_rem_sh >= {1'b0, w_den}) begin
                r_rem <= w_rem_sub[POS_W-1:0];
                r_quo <= {r_quo[CMP_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[POS_W-1:0];
                r_quo <= {r_quo[CMP_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        priority if (r_lo) begin
            o_next = i_cfg.pwm_min;
        end else if (r_hi) begin
            o_next = i_cfg.pwm_max;
        end else begin
            o_next = i_cfg.pwm_min + r_quo;
        end
    end

endmodule

>>> rtl/svpm_merge.sv
// merging stage: deadband test of every lane against its held compare value
// depends on svpm_pkg
module svpm_merge
    import svpm_pkg::*;
(
    input  logic [CMP_W-1:0] i_next [LANES],
    input  logic [CMP_W-1:0] i_held [LANES],
    input  logic [CMP_W-1:0] i_threshold,
    input  logic             i_filter,
    output logic [CMP_W-1:0] o_compare [LANES],
    output logic             o_updated [LANES]
);

    logic [CMP_W-1:0] w_diff [LANES];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_diff[i]    = (i_next[i] >= i_held[i]) ? (i_next[i] - i_held[i])
                                                    : (i_held[i] - i_next[i]);
            o_updated[i] = !i_filter || (w_diff[i] > i_threshold);
            o_compare[i] = o_updated[i] ? i_next[i] : i_held[i];
        end
    end

endmodule

>>> rtl/servo_pwm_map_deadband.sv
// top level of the servo compare mapper: config registers, sequencer, lanes and result register
// depends on svpm_pkg, svpm_lane and svpm_merge
//
// Maps four joint positions onto servo compare values, one lane per channel working side by
// side, and holds the last value written for each channel. An input word is taken only while
// the sequencer is idle; the range test is registered as the word is taken, and the result
// register is filled after the span multiply, the restoring divide that every lane runs in
// step, and the deadband merge. A new word can be taken the cycle after that write, so no
// word is taken before the last one is through. The result register frees the
// input side, so the next word can be taken while a finished result waits to be collected;
// the merge waits only if the previous result is still uncollected. Configuration registers
// are written through a plain write port and must only change while the block is idle.
module servo_pwm_map_deadband
    import svpm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_data
);

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pot_min          <= POS_W'(0);
            r_cfg.pot_max          <= POS_W'(4095);
            r_cfg.pwm_min          <= CMP_W'(1000);
            r_cfg.pwm_max          <= CMP_W'(5000);
            r_cfg.change_threshold <= CMP_W'(10);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_POT_MIN:   r_cfg.pot_min          <= i_cfg_data[POS_W-1:0];
                REG_POT_MAX:   r_cfg.pot_max          <= i_cfg_data[POS_W-1:0];
                REG_PWM_MIN:   r_cfg.pwm_min          <= i_cfg_data[CMP_W-1:0];
                REG_PWM_MAX:   r_cfg.pwm_max          <= i_cfg_data[CMP_W-1:0];
                REG_THRESHOLD: r_cfg.change_threshold <= i_cfg_data[CMP_W-1:0];
                default: ; // unknown index, write dropped
            endcase
        end
    end

    // sequencer
    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_filter;
    t_lane_ctl        w_ctl;
    logic             w_in_acc;
    logic             w_write;

    assign w_in_acc   = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        w_ctl      = '0;
        w_write    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                w_ctl.load = 1'b1;
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                w_ctl.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                w_ctl.step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // result register must be free or emptying this cycle
                if (!o_out_valid || i_out_ready) begin
                    w_write = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_filter <= i_in_data.filter_on;
        end
    end

    // lanes, one per channel with an input
    logic [POS_W-1:0] w_pos  [IN_CHANNELS];
    logic [CMP_W-1:0] w_next [LANES];

    assign w_pos[0] = i_in_data.base_position;
    assign w_pos[1] = i_in_data.elbow_position;
    assign w_pos[2] = i_in_data.wrist_position;
    assign w_pos[3] = i_in_data.gripper_position;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        svpm_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_cfg  (r_cfg),
            .i_pos  (w_pos[g]),
            .o_next (w_next[g])
        );
    end

    // held compare values and deadband merge
    logic [CMP_W-1:0] r_last    [LANES];
    logic [CMP_W-1:0] w_compare [LANES];
    logic             w_updated [LANES];

    svpm_merge u_merge (
        .i_next      (w_next),
        .i_held      (r_last),
        .i_threshold (r_cfg.change_threshold),
        .i_filter    (r_filter),
        .o_compare   (w_compare),
        .o_updated   (w_updated)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) begin
                r_last[i] <= '0;
            end
        end else if (w_write) begin
            for (int i = 0; i < LANES; i++) begin
                r_last[i] <= w_compare[i];
            end
        end
    end

    // result word: channels without a lane read as zero
    logic [CMP_W-1:0] w_cmp_all [IN_CHANNELS];
    logic             w_upd_all [IN_CHANNELS];
    t_out_word        w_out;

    always_comb begin
        for (int i = 0; i < IN_CHANNELS; i++) begin
            w_cmp_all[i] = '0;
            w_upd_all[i] = 1'b0;
        end
        for (int i = 0; i < LANES; i++) begin
            w_cmp_all[i] = w_compare[i];
            w_upd_all[i] = w_updated[i];
        end
        w_out.base_compare    = w_cmp_all[0];
        w_out.elbow_compare   = w_cmp_all[1];
        w_out.wrist_compare   = w_cmp_all[2];
        w_out.gripper_compare = w_cmp_all[3];
        w_out.base_updated    = w_upd_all[0];
        w_out.elbow_updated   = w_upd_all[1];
        w_out.wrist_updated   = w_upd_all[2];
        w_out.gripper_updated = w_upd_all[3];
    end

    // result register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_write) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            o_out_data <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;

    // checks
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_MUL))
        else $error("accepted word did not start the multiply");

    a_divide_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == CNT_W'(DIV_STEPS - 1)) |=> (r_state == S_DONE))
        else $error("divide did not finish after the last step");

    a_write_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_write |=> o_out_valid)
        else $error("merged result not presented");

    a_unfiltered_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_write && !r_filter) |=> ($countones({o_out_data.base_updated,
            o_out_data.elbow_updated, o_out_data.wrist_updated,
            o_out_data.gripper_updated}) == LANES))
        else $error("unfiltered word left a channel unchanged");

endmodule
